[rtl/hpe_pkg.sv]
// Shared types and constants for the Horner polynomial evaluator.
package hpe_pkg;

  // Fixed widths of the data path.
  localparam int DATA_W = 32;
  localparam int ACC_W  = 66;

  // Register map: paddr[2] selects the register word.
  localparam logic REG_DEGREE = 1'b0;

  // Input item commands.
  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_REAL  = 2'd1,
    CMD_DERIV = 2'd2,
    CMD_CPLX  = 2'd3
  } cmd_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_MUL,
    ST_ACC,
    ST_CLAMP,
    ST_DONE
  } state_t;

  // Multiplier operand selects.
  typedef enum logic [1:0] {
    OPA_VAL,
    OPA_IM,
    OPA_DER
  } opa_t;

  typedef enum logic {
    OPB_X,
    OPB_Y
  } opb_t;

  // Command group from the controller to the datapath.
  typedef struct packed {
    logic capture;   // latch the evaluation point
    logic wr_en;     // write one coefficient
    logic rd_en;     // read one coefficient
    logic start;     // load the leading coefficient, clear the others
    logic mul_go;    // issue one product
    opa_t mul_a;
    opb_t mul_b;
    logic acc_sel_b; // product goes to accumulator B
    logic acc_sub;   // product is subtracted
    logic acc_init;  // preset both accumulators for a new step
    logic clamp;     // saturate accumulators into the working values
    logic out_load;  // move the working values into the result register
    cmd_t mode;
  } ctl_t;

endpackage

[rtl/hpe_ifs.sv]
// Valid/ready channel interfaces for input and result items.
interface hpe_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic [3:0]         coeff_index;
  logic signed [31:0] coeff_value;
  logic signed [31:0] x_re;
  logic signed [31:0] x_im;

  modport source (output valid, cmd, coeff_index, coeff_value, x_re, x_im, input ready);
  modport sink   (input valid, cmd, coeff_index, coeff_value, x_re, x_im, output ready);
endinterface

interface hpe_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value_re;
  logic signed [31:0] value_im;
  logic signed [31:0] slope;
  logic               overflow;

  modport source (output valid, value_re, value_im, slope, overflow, input ready);
  modport sink   (input valid, value_re, value_im, slope, overflow, output ready);
endinterface

[rtl/hpe_ctrl.sv]
// Controller state machine that sequences Horner steps and product issue.
module hpe_ctrl #(
  parameter int MAX_ORDER = 15,
  parameter int IDX_W     = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [3:0]        degree,
  input  logic              in_valid,
  input  logic [1:0]        in_cmd,
  input  logic [3:0]        in_coeff_index,
  output logic              in_ready,
  input  logic              out_ready,
  output logic              out_valid,
  output hpe_pkg::ctl_t     ctl,
  output logic [IDX_W-1:0]  rd_addr,
  output logic [IDX_W-1:0]  wr_addr
);

  hpe_pkg::state_t state_r, state_nxt;
  hpe_pkg::cmd_t   mode_r, mode_nxt;
  hpe_pkg::cmd_t   in_cmd_e;
  logic [IDX_W-1:0] i_r, i_nxt;
  logic [1:0]       k_r, k_nxt, k_last;
  logic [IDX_W-1:0] n_eff;
  logic             accept, idx_ok, out_free, out_valid_r, out_valid_nxt;

  assign in_cmd_e = hpe_pkg::cmd_t'(in_cmd);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign idx_ok   = ({5'b0, in_coeff_index} <= 9'(MAX_ORDER));
  assign wr_addr  = IDX_W'(in_coeff_index);
  assign out_valid = out_valid_r;

  // A degree above MAX_ORDER acts as the top of the store.
  always_comb begin
    if ({5'b0, degree} > 9'(MAX_ORDER)) begin
      n_eff = IDX_W'(MAX_ORDER);
    end else begin
      n_eff = IDX_W'(degree);
    end
  end

  // Index of the last product of one step for each mode.
  always_comb begin
    unique case (mode_r)
      hpe_pkg::CMD_DERIV: k_last = 2'd1;
      hpe_pkg::CMD_CPLX:  k_last = 2'd3;
      default:            k_last = 2'd0;
    endcase
  end

  // Next state and counters.
  always_comb begin
    state_nxt = state_r;
    mode_nxt  = mode_r;
    i_nxt     = i_r;
    k_nxt     = k_r;
    unique case (state_r)
      hpe_pkg::ST_IDLE: begin
        if (accept && in_cmd_e != hpe_pkg::CMD_LOAD) begin
          state_nxt = hpe_pkg::ST_INIT;
          mode_nxt  = in_cmd_e;
          i_nxt     = n_eff;
        end
      end
      hpe_pkg::ST_INIT, hpe_pkg::ST_CLAMP: begin
        if (i_r == '0) begin
          state_nxt = hpe_pkg::ST_DONE;
        end else begin
          state_nxt = hpe_pkg::ST_MUL;
          i_nxt     = i_r - 1'b1;
          k_nxt     = 2'd0;
        end
      end
      hpe_pkg::ST_MUL: begin
        if (k_r == k_last) begin
          state_nxt = hpe_pkg::ST_ACC;
        end else begin
          k_nxt = k_r + 2'd1;
        end
      end
      hpe_pkg::ST_ACC: state_nxt = hpe_pkg::ST_CLAMP;
      hpe_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = hpe_pkg::ST_IDLE;
        end
      end
      default: state_nxt = hpe_pkg::ST_IDLE;
    endcase
  end

  // Command outputs for the datapath.
  always_comb begin
    ctl           = '0;
    ctl.mode      = mode_r;
    ctl.mul_a     = hpe_pkg::OPA_VAL;
    ctl.mul_b     = hpe_pkg::OPB_X;
    in_ready      = 1'b0;
    rd_addr       = i_r - 1'b1;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      hpe_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        rd_addr  = n_eff;
        if (accept) begin
          if (in_cmd_e == hpe_pkg::CMD_LOAD) begin
            ctl.wr_en = idx_ok;
          end else begin
            ctl.capture = 1'b1;
            ctl.rd_en   = 1'b1;
          end
        end
      end
      hpe_pkg::ST_INIT: begin
        ctl.start = 1'b1;
        ctl.rd_en = (i_r != '0);
      end
      hpe_pkg::ST_MUL: begin
        ctl.mul_go   = 1'b1;
        ctl.acc_init = (k_r == 2'd0);
        unique case (mode_r)
          hpe_pkg::CMD_DERIV: begin
            if (k_r == 2'd0) begin
              ctl.mul_a     = hpe_pkg::OPA_DER;
              ctl.acc_sel_b = 1'b1;
            end
          end
          hpe_pkg::CMD_CPLX: begin
            unique case (k_r)
              2'd1: begin
                ctl.mul_a   = hpe_pkg::OPA_IM;
                ctl.mul_b   = hpe_pkg::OPB_Y;
                ctl.acc_sub = 1'b1;
              end
              2'd2: begin
                ctl.mul_b     = hpe_pkg::OPB_Y;
                ctl.acc_sel_b = 1'b1;
              end
              2'd3: begin
                ctl.mul_a     = hpe_pkg::OPA_IM;
                ctl.acc_sel_b = 1'b1;
              end
              default: ;
            endcase
          end
          default: ;
        endcase
      end
      hpe_pkg::ST_ACC: ;
      hpe_pkg::ST_CLAMP: begin
        ctl.clamp = 1'b1;
        ctl.rd_en = (i_r != '0);
      end
      hpe_pkg::ST_DONE: begin
        if (out_free) begin
          ctl.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // State and counter registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hpe_pkg::ST_IDLE;
      mode_r      <= hpe_pkg::CMD_REAL;
      i_r         <= '0;
      k_r         <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      i_r         <= i_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[rtl/hpe_datapath.sv]
// Coefficient store, shared multiplier, accumulators and result register.
module hpe_datapath #(
  parameter int MAX_ORDER = 15,
  parameter int FRAC_BITS = 16,
  parameter int IDX_W     = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  hpe_pkg::ctl_t      ctl,
  input  logic [IDX_W-1:0]   rd_addr,
  input  logic [IDX_W-1:0]   wr_addr,
  input  logic signed [31:0] in_coeff_value,
  input  logic signed [31:0] in_x_re,
  input  logic signed [31:0] in_x_im,
  output logic signed [31:0] res_re,
  output logic signed [31:0] res_im,
  output logic signed [31:0] res_slope,
  output logic               res_ovf
);

  localparam int DEPTH = MAX_ORDER + 1;
  localparam int AW    = hpe_pkg::ACC_W;
  localparam logic [63:0] RND_MASK = (FRAC_BITS > 0) ? (64'd1 << (FRAC_BITS - 1)) : 64'd0;

  logic signed [31:0] mem [DEPTH];
  logic [DEPTH-1:0]   vld_r;
  logic signed [31:0] rdata_r;
  logic               rvld_r;
  logic signed [31:0] coef;

  logic signed [31:0] x_r, y_r, val_r, im_r, der_r;
  logic signed [31:0] op_a, op_b;
  logic signed [63:0] prod, prod_r;
  logic               go_r, sel_b_r, sub_r, ovf_r;
  logic [AW-1:0]      acc_a_r, acc_b_r, acc_src, s_ext, addend, acc_sum;
  logic               rbit, cin;
  logic [32:0]        sat_a, sat_b;

  logic signed [31:0] res_re_r, res_im_r, res_slope_r;
  logic               res_ovf_r;

  // Saturate a wide sum to 32 bits; bit 32 flags saturation.
  function automatic logic [32:0] sat32(input logic [AW-1:0] v);
    logic same;
    same = (&v[AW-1:31]) || !(|v[AW-1:31]);
    if (same) begin
      sat32 = {1'b0, v[31:0]};
    end else if (v[AW-1]) begin
      sat32 = {1'b1, 32'h8000_0000};
    end else begin
      sat32 = {1'b1, 32'h7FFF_FFFF};
    end
  endfunction

  // Coefficient store with registered read.
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= in_coeff_value;
    end
    if (ctl.rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // Per-entry written flags; an entry never written reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      rvld_r <= 1'b0;
    end else begin
      if (ctl.wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (ctl.rd_en) begin
        rvld_r <= vld_r[rd_addr];
      end
    end
  end

  assign coef = rvld_r ? rdata_r : 32'sd0;

  // Operand selection for the shared multiplier.
  always_comb begin
    unique case (ctl.mul_a)
      hpe_pkg::OPA_IM:  op_a = im_r;
      hpe_pkg::OPA_DER: op_a = der_r;
      default:          op_a = val_r;
    endcase
    unique case (ctl.mul_b)
      hpe_pkg::OPB_Y: op_b = y_r;
      default:        op_b = x_r;
    endcase
  end

  assign prod = op_a * op_b;

  // Round half up folded into the accumulate: floor(p/2^F) plus bit F-1 of p.
  // Subtraction uses the inverted term with the inverted rounding bit as carry.
  always_comb begin
    s_ext   = AW'(prod_r >>> FRAC_BITS);
    rbit    = |(prod_r & RND_MASK);
    addend  = sub_r ? ~s_ext : s_ext;
    cin     = sub_r ? !rbit : rbit;
    acc_src = sel_b_r ? acc_b_r : acc_a_r;
    acc_sum = acc_src + addend + AW'(cin);
  end

  assign sat_a = sat32(acc_a_r);
  assign sat_b = sat32(acc_b_r);

  // Product register and its accumulate tag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      go_r <= 1'b0;
    end else begin
      go_r <= ctl.mul_go;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.mul_go) begin
      prod_r  <= prod;
      sel_b_r <= ctl.acc_sel_b;
      sub_r   <= ctl.acc_sub;
    end
  end

  // Accumulators: preset at the start of a step, then one product a cycle.
  always_ff @(posedge clk) begin
    if (ctl.acc_init) begin
      acc_a_r <= {{(AW-32){coef[31]}}, coef};
      if (ctl.mode == hpe_pkg::CMD_DERIV) begin
        acc_b_r <= {{(AW-32){val_r[31]}}, val_r};
      end else begin
        acc_b_r <= '0;
      end
    end else if (go_r) begin
      if (sel_b_r) begin
        acc_b_r <= acc_sum;
      end else begin
        acc_a_r <= acc_sum;
      end
    end
  end

  // Evaluation point and working values.
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      x_r <= in_x_re;
      y_r <= in_x_im;
    end
    if (ctl.start) begin
      val_r <= coef;
      im_r  <= 32'sd0;
      der_r <= 32'sd0;
      ovf_r <= 1'b0;
    end else if (ctl.clamp) begin
      val_r <= sat_a[31:0];
      unique case (ctl.mode)
        hpe_pkg::CMD_DERIV: begin
          der_r <= sat_b[31:0];
          ovf_r <= ovf_r | sat_a[32] | sat_b[32];
        end
        hpe_pkg::CMD_CPLX: begin
          im_r  <= sat_b[31:0];
          ovf_r <= ovf_r | sat_a[32] | sat_b[32];
        end
        default: ovf_r <= ovf_r | sat_a[32];
      endcase
    end
  end

  // Result register, loaded once the result channel has room.
  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      res_re_r    <= val_r;
      res_im_r    <= im_r;
      res_slope_r <= der_r;
      res_ovf_r   <= ovf_r;
    end
  end

  assign res_re    = res_re_r;
  assign res_im    = res_im_r;
  assign res_slope = res_slope_r;
  assign res_ovf   = res_ovf_r;

endmodule

[rtl/horner_poly_evaluator_unit.sv]
// Top level of the Horner polynomial evaluator with its register port.
//
//  Channel   Dir   Handshake            Content
//  in_ch     in    valid/ready          cmd, coeff_index, coeff_value, x_re, x_im
//  out_ch    out   valid/ready          value_re, value_im, slope, overflow
//  APB       in    psel/penable/pready  degree register at byte address 0
//
// A load item is written to the store as it is taken. An evaluation of degree
// n runs n Horner steps of one product for a real point, two with the
// derivative and four for a complex point; one shared 32x32 multiplier issues
// one product a cycle, and each Horner step waits for its saturated results.
// Reset is synchronous and clears the degree register, the store flags and the controller.
// A full result register holds the controller until out_ch takes the item.
module horner_poly_evaluator_unit #(
  parameter int MAX_ORDER = 15,
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  hpe_in_if.sink      in_ch,
  hpe_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IDX_W = (MAX_ORDER > 0) ? $clog2(MAX_ORDER + 1) : 1;

  logic [3:0]       degree_r;
  logic             cfg_wr;
  hpe_pkg::ctl_t    ctl;
  logic [IDX_W-1:0] rd_addr, wr_addr;

  // Configuration register.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == hpe_pkg::REG_DEGREE);
  assign prdata = (paddr[2] == hpe_pkg::REG_DEGREE) ? {28'd0, degree_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      degree_r <= 4'd0;
    end else if (cfg_wr) begin
      degree_r <= pwdata[3:0];
    end
  end

  hpe_ctrl #(
    .MAX_ORDER(MAX_ORDER),
    .IDX_W    (IDX_W)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .degree        (degree_r),
    .in_valid      (in_ch.valid),
    .in_cmd        (in_ch.cmd),
    .in_coeff_index(in_ch.coeff_index),
    .in_ready      (in_ch.ready),
    .out_ready     (out_ch.ready),
    .out_valid     (out_ch.valid),
    .ctl           (ctl),
    .rd_addr       (rd_addr),
    .wr_addr       (wr_addr)
  );

  hpe_datapath #(
    .MAX_ORDER(MAX_ORDER),
    .FRAC_BITS(FRAC_BITS),
    .IDX_W    (IDX_W)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl           (ctl),
    .rd_addr       (rd_addr),
    .wr_addr       (wr_addr),
    .in_coeff_value(in_ch.coeff_value),
    .in_x_re       (in_ch.x_re),
    .in_x_im       (in_ch.x_im),
    .res_re        (out_ch.value_re),
    .res_im        (out_ch.value_im),
    .res_slope     (out_ch.slope),
    .res_ovf       (out_ch.overflow)
  );

  // A load item leaves the block ready for the next item.
  a_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.cmd == hpe_pkg::CMD_LOAD) |=> in_ch.ready)
    else $error("block busy after a load item");

  // An evaluate item makes the block busy on the next cycle.
  a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.cmd != hpe_pkg::CMD_LOAD) |=> !in_ch.ready)
    else $error("block still ready after an evaluate item");

  // A new result never overwrites one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.out_load |-> (!out_ch.valid || out_ch.ready))
    else $error("result register overwritten");

  // The store is written only by an accepted load item.
  a_store_write: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.wr_en |-> (in_ch.valid && in_ch.ready && in_ch.cmd == hpe_pkg::CMD_LOAD))
    else $error("coefficient write without a load item");

endmodule

[bench/tb_top.sv]
// Self-checking testbench for the Horner polynomial evaluator in all three modes.
module tb_top;

  localparam int FRAC         = 16;
  localparam int ORDER_MAX    = 15;
  localparam int DRAIN_CYCLES = 6 * ORDER_MAX + 12;
  localparam int STALL_LIMIT  = 4000;
  localparam int PHASE_ITEMS  = 105;

  typedef struct {
    hpe_pkg::cmd_t      cmd;
    logic [3:0]         idx;
    logic signed [31:0] coef;
    logic signed [31:0] x_re;
    logic signed [31:0] x_im;
  } poly_item_t;

  typedef struct {
    logic signed [31:0] re;
    logic signed [31:0] im;
    logic signed [31:0] slope;
    logic               ovf;
  } poly_result_t;

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  hpe_in_if  in_ch();
  hpe_out_if out_ch();

  horner_poly_evaluator_unit dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow copy of the coefficient store and the degree register.
  logic signed [31:0] coef_shadow [16];
  int                 degree_model;

  poly_item_t   items_waiting[$];
  poly_result_t results_due[$];
  poly_item_t   cur_item;
  poly_result_t seen;
  poly_result_t want;

  bit no_idle;
  int mismatches;
  int n_loads, n_evals, n_results, n_ovf, n_phases, n_queued;
  int stall_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("MISMATCH: %s", msg);
  endtask

  // Product of two Q16.16 values, rounded half up to the fraction width.
  function automatic longint fx_mul(input longint a, input longint b);
    longint p;
    p = a * b + (64'sd1 <<< (FRAC - 1));
    return p >>> FRAC;
  endfunction

  function automatic longint sat32(input longint v, inout bit ovf);
    if (v > 64'sd2147483647) begin
      ovf = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      ovf = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  // Applies one accepted item to the shadow store and queues the result it causes.
  function automatic void horner_predict(input poly_item_t it);
    longint       val, der, im, c, x, y, nr, ni;
    bit           ovf;
    poly_result_t r;
    if (it.cmd == hpe_pkg::CMD_LOAD) begin
      coef_shadow[it.idx] = it.coef;
      n_loads++;
      return;
    end
    n_evals++;
    x   = it.x_re;
    y   = it.x_im;
    val = coef_shadow[degree_model];
    der = 0;
    im  = 0;
    ovf = 1'b0;
    for (int i = degree_model - 1; i >= 0; i--) begin
      c = coef_shadow[i];
      case (it.cmd)
        hpe_pkg::CMD_REAL: begin
          val = sat32(fx_mul(val, x) + c, ovf);
        end
        hpe_pkg::CMD_DERIV: begin
          der = sat32(fx_mul(der, x) + val, ovf);
          val = sat32(fx_mul(val, x) + c, ovf);
        end
        default: begin
          nr  = fx_mul(val, x) - fx_mul(im, y) + c;
          ni  = fx_mul(val, y) + fx_mul(im, x);
          val = sat32(nr, ovf);
          im  = sat32(ni, ovf);
        end
      endcase
    end
    r.re    = val[31:0];
    r.im    = im[31:0];
    r.slope = der[31:0];
    r.ovf   = ovf;
    results_due.push_back(r);
  endfunction

  // Random Q16.16 value: mostly within +/- 2^(bits-17), with extremes and
  // full-range values mixed in.
  function automatic logic signed [31:0] rand_fix(input int bits);
    int r;
    r = $urandom_range(99);
    if (r < 4) return 32'sh7fffffff;
    if (r < 8) return 32'sh80000000;
    if (r < 18) return $urandom;
    return $urandom_range(0, (1 << bits) - 1) - (1 << (bits - 1));
  endfunction

  task automatic push_load(input int idx, input logic signed [31:0] value);
    poly_item_t it;
    it.cmd  = hpe_pkg::CMD_LOAD;
    it.idx  = idx[3:0];
    it.coef = value;
    it.x_re = $urandom;
    it.x_im = $urandom;
    items_waiting.push_back(it);
    n_queued++;
  endtask

  task automatic push_eval(input hpe_pkg::cmd_t cmd, input logic signed [31:0] xr,
                           input logic signed [31:0] xi);
    poly_item_t it;
    it.cmd  = cmd;
    it.idx  = 4'($urandom);
    it.coef = $urandom;
    it.x_re = xr;
    it.x_im = xi;
    items_waiting.push_back(it);
    n_queued++;
  endtask

  // Mostly short load-then-evaluate sequences with random content, plus some fully random items.
  task automatic fill_random_phase(input int target);
    int         start;
    int         pick;
    poly_item_t it;
    start = n_queued;
    while (n_queued - start < target) begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        for (int i = 0; i <= degree_model; i++) push_load(i, rand_fix(20));
        push_eval(hpe_pkg::cmd_t'($urandom_range(1, 3)), rand_fix(18), rand_fix(18));
      end else if (pick < 80) begin
        repeat ($urandom_range(1, 3)) begin
          if ($urandom_range(4) == 0) push_load($urandom_range(0, 15), rand_fix(20));
          else push_load($urandom_range(0, degree_model), rand_fix(20));
        end
        repeat ($urandom_range(1, 3))
          push_eval(hpe_pkg::cmd_t'($urandom_range(1, 3)), rand_fix(18), rand_fix(18));
      end else begin
        it.cmd  = hpe_pkg::cmd_t'($urandom_range(0, 3));
        it.idx  = 4'($urandom);
        it.coef = $urandom;
        it.x_re = $urandom;
        it.x_im = $urandom;
        items_waiting.push_back(it);
        n_queued++;
      end
    end
  endtask

  // Register write: setup cycle, then access until pready.
  task automatic degree_write(input int d);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {hpe_pkg::REG_DEGREE, 2'b00};
    pwdata  <= d;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    degree_model = d;
    n_phases++;
  endtask

  task automatic degree_check();
    logic [31:0] got;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {hpe_pkg::REG_DEGREE, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got[3:0] != degree_model[3:0])
      note_mismatch($sformatf("degree readback expected %0d actual %0d",
                              degree_model, got[3:0]));
  endtask

  // Waits until every queued item is taken and every expected result has come back.
  task automatic wait_drained();
    do @(negedge clk);
    while (items_waiting.size() != 0 || in_ch.valid || results_due.size() != 0);
  endtask

  task automatic new_setting(input int d);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    degree_write(d);
    degree_check();
    @(negedge clk);
  endtask

  // Input driver: holds an item until it is taken, idles at random between items.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) horner_predict(cur_item);
      if (!in_ch.valid || in_ch.ready) begin
        if (items_waiting.size() != 0 && (no_idle || $urandom_range(99) >= 10)) begin
          cur_item = items_waiting.pop_front();
          in_ch.valid       <= 1'b1;
          in_ch.cmd         <= cur_item.cmd;
          in_ch.coeff_index <= cur_item.idx;
          in_ch.coeff_value <= cur_item.coef;
          in_ch.x_re        <= cur_item.x_re;
          in_ch.x_im        <= cur_item.x_im;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compares each taken result with the oldest expectation.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        n_results++;
        seen.re    = out_ch.value_re;
        seen.im    = out_ch.value_im;
        seen.slope = out_ch.slope;
        seen.ovf   = out_ch.overflow;
        if (seen.ovf) n_ovf++;
        if (results_due.size() == 0) begin
          note_mismatch($sformatf("unexpected result re=%h im=%h slope=%h ovf=%b",
                                  seen.re, seen.im, seen.slope, seen.ovf));
        end else begin
          want = results_due.pop_front();
          if (seen.re !== want.re || seen.im !== want.im ||
              seen.slope !== want.slope || seen.ovf !== want.ovf)
            note_mismatch($sformatf(
              "result %0d expected re=%h im=%h slope=%h ovf=%b actual re=%h im=%h slope=%h ovf=%b",
              n_results, want.re, want.im, want.slope, want.ovf,
              seen.re, seen.im, seen.slope, seen.ovf));
        end
      end
      out_ch.ready <= no_idle || $urandom_range(99) >= 10;
    end
  end

  // Watchdog on cycles in which nothing moves on any port.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || (psel && penable))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Watchdog: nothing moved for %0d cycles", STALL_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.cmd         = hpe_pkg::CMD_LOAD;
    in_ch.coeff_index = '0;
    in_ch.coeff_value = '0;
    in_ch.x_re        = '0;
    in_ch.x_im        = '0;
    out_ch.ready      = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    no_idle           = 1'b0;
    degree_model      = 0;
    for (int i = 0; i < 16; i++) coef_shadow[i] = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: store cleared at reset, degree zero gives c[0] alone.
    push_eval(hpe_pkg::CMD_REAL, 32'sh00010000, 32'sh0);
    new_setting(0);
    push_load(0, 32'sh7fffffff);
    push_eval(hpe_pkg::CMD_REAL, 32'sh80000000, 32'sh7fffffff);
    push_eval(hpe_pkg::CMD_DERIV, 32'sh7fffffff, 32'sh80000000);
    push_eval(hpe_pkg::CMD_CPLX, 32'sh7fffffff, 32'sh80000000);
    push_load(15, 32'sh80000000);

    // Directed: full order with extreme coefficients and points.
    new_setting(ORDER_MAX);
    push_eval(hpe_pkg::CMD_REAL, 32'sh00010000, 32'sh0);
    push_eval(hpe_pkg::CMD_REAL, 32'sh7fffffff, 32'sh0);
    push_eval(hpe_pkg::CMD_DERIV, 32'sh80000000, 32'sh0);
    push_eval(hpe_pkg::CMD_CPLX, 32'sh80000000, 32'sh7fffffff);
    push_load(0, 32'sh80000000);
    push_load(7, 32'sh00018000);
    push_eval(hpe_pkg::CMD_CPLX, 32'sh0, 32'sh00010000);
    push_eval(hpe_pkg::CMD_DERIV, 32'shffff0000, 32'sh0);
    push_eval(hpe_pkg::CMD_REAL, 32'sh00008000, 32'sh0);

    // Random phases over several degrees; one phase runs with no idling on either side.
    for (int ph = 0; ph < 12; ph++) begin
      case (ph)
        0: new_setting(ORDER_MAX);
        1: new_setting(0);
        2: new_setting(1);
        3: new_setting(2);
        4: new_setting(3);
        5: new_setting(5);
        6: new_setting(ORDER_MAX);
        7: new_setting(7);
        11: new_setting(4);
        default: new_setting($urandom_range(0, ORDER_MAX));
      endcase
      no_idle = (ph == 6);
      fill_random_phase(PHASE_ITEMS);
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d loads and %0d evaluations over %0d degree settings.",
             n_loads, n_evals, n_phases);
    $display("Checked %0d results, %0d of them saturated; %0d mismatches.",
             n_results, n_ovf, mismatches);
    if (mismatches == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
